[rtl/upd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package upd_pkg;

    // Character codes
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    // 'A' - 10 and 'a' - 10
    localparam logic [7:0] UPPER_OFS = 8'h37;
    localparam logic [7:0] LOWER_OFS = 8'h57;

    // Default number of jobs between front and back
    localparam int QUEUE_DEPTH = 4;

    // Escape tracking
    typedef enum logic [1:0] {
        PH_PLAIN,
        PH_PCT,
        PH_DIGIT
    } phase_t;

    // Up to three decoded bytes caused by one input character
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
        logic            last;
    } job_t;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_UA) && (c <= CH_UF)) ||
               ((c >= CH_LA) && (c <= CH_LF));
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] t;
        if (c >= CH_LA) begin
            t = c - LOWER_OFS;
        end else if (c >= CH_UA) begin
            t = c - UPPER_OFS;
        end else begin
            t = c - CH_0;
        end
        return t[3:0];
    endfunction

endpackage

`default_nettype wire

[rtl/url_percent_decoder_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Each job waits in one of QUEUE_DEPTH queue slots, then its bytes go out registered.
// Throughput: one input character per cycle while each gives at most one
// byte, the queue is not full and m_tready is high; a failed escape gives up
// to three bytes, sent one by one from one job while the queue absorbs input.
// Reset: synchronous, active low; clears escape state, queue and output valid.
module url_percent_decoder_top #(
    parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_char
    input  wire logic        s_tlast,   // in_last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_char
    output logic             m_tlast,   // out_string_end
    output logic [0:0]       m_tuser    // [0] out_run_end
);

    upd_pkg::job_t new_job;
    upd_pkg::job_t head_job;
    logic          job_push;
    logic          job_pop;
    logic          q_empty;
    logic          q_full;
    logic          in_fire;

    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    upd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_char  (s_tdata),
        .in_last  (s_tlast),
        .job      (new_job),
        .job_push (job_push)
    );

    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (job_push),
        .wr_job  (new_job),
        .pop     (job_pop),
        .head    (head_job),
        .empty   (q_empty),
        .full    (q_full)
    );

    upd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head_job),
        .empty    (q_empty),
        .pop      (job_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

[rtl/upd_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module upd_front (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_fire,
    input  wire logic [7:0]   in_char,
    input  wire logic         in_last,
    output upd_pkg::job_t     job,
    output logic              job_push
);

    upd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      held_reg, held_next;
    logic            c_hex;
    logic            c_pct;

    assign c_hex = upd_pkg::is_hex(in_char);
    assign c_pct = (in_char == upd_pkg::CH_PCT);

    // Next escape state
    always_comb begin
        phase_next = upd_pkg::PH_PLAIN;
        held_next  = held_reg;
        unique case (phase_reg)
            upd_pkg::PH_DIGIT: begin
                held_next = 8'd0;
                if (!c_hex && c_pct && !in_last) begin
                    phase_next = upd_pkg::PH_PCT;
                end
            end
            upd_pkg::PH_PCT: begin
                if (c_hex && !in_last) begin
                    held_next  = in_char;
                    phase_next = upd_pkg::PH_DIGIT;
                end else if (c_pct && !in_last) begin
                    phase_next = upd_pkg::PH_PCT;
                end
            end
            default: begin
                if (c_pct && !in_last) begin
                    phase_next = upd_pkg::PH_PCT;
                end
            end
        endcase
        if (in_last) begin
            phase_next = upd_pkg::PH_PLAIN;
            held_next  = 8'd0;
        end
    end

    // Bytes produced by this character
    always_comb begin
        logic done;
        done      = 1'b0;
        job.bytes = '0;
        job.count = 2'd0;
        job.last  = in_last;
        unique case (phase_reg)
            upd_pkg::PH_DIGIT: begin
                if (c_hex) begin
                    job.bytes[job.count] = {upd_pkg::hex_value(held_reg),
                                            upd_pkg::hex_value(in_char)};
                    job.count = job.count + 2'd1;
                    done = 1'b1;
                end else begin
                    job.bytes[job.count] = upd_pkg::CH_PCT;
                    job.count = job.count + 2'd1;
                    job.bytes[job.count] = held_reg;
                    job.count = job.count + 2'd1;
                end
            end
            upd_pkg::PH_PCT: begin
                if (c_hex && !in_last) begin
                    done = 1'b1;
                end else begin
                    job.bytes[job.count] = upd_pkg::CH_PCT;
                    job.count = job.count + 2'd1;
                end
            end
            default: begin
                done = 1'b0;
            end
        endcase
        if (!done) begin
            if (c_pct) begin
                if (in_last) begin
                    job.bytes[job.count] = upd_pkg::CH_PCT;
                    job.count = job.count + 2'd1;
                end
            end else if (in_char == upd_pkg::CH_PLUS) begin
                job.bytes[job.count] = upd_pkg::CH_SPACE;
                job.count = job.count + 2'd1;
            end else begin
                job.bytes[job.count] = in_char;
                job.count = job.count + 2'd1;
            end
        end
    end

    // Only characters that give output make a job
    assign job_push = in_fire && (job.count != 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= upd_pkg::PH_PLAIN;
            held_reg  <= 8'd0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

`ifndef SYNTH
    // A held digit exists only while the second digit is awaited
    a_held_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != upd_pkg::PH_DIGIT) |-> (held_reg == 8'd0))
        else $error("held digit outside digit phase");
    // Nothing stays pending past the end of a string
    a_last_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && in_last) |=> (phase_reg == upd_pkg::PH_PLAIN))
        else $error("escape pending after string end");
`endif

endmodule

`default_nettype wire

[rtl/upd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module upd_queue #(
    parameter int DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire upd_pkg::job_t wr_job,
    input  wire logic          pop,
    output upd_pkg::job_t      head,
    output logic               empty,
    output logic               full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    upd_pkg::job_t  slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == FULL_CNT);
    assign head  = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("job queue underflow");
`endif

endmodule

`default_nettype wire

[rtl/upd_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module upd_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire upd_pkg::job_t head,
    input  wire logic          empty,
    output logic               pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast,
    output logic [0:0]         m_tuser
);

    logic [1:0] pos_reg, pos_next;
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;
    logic       m_tuser_reg;
    logic       load;
    logic       take;
    logic       run_end;
    logic [7:0] cur_byte;

    // Output register free or being drained this cycle
    assign load    = !m_tvalid_reg || m_tready;
    assign take    = load && !empty;
    assign run_end = (pos_reg == (head.count - 2'd1));
    assign pop     = take && run_end;

    always_comb begin
        case (pos_reg)
            2'd0:    cur_byte = head.bytes[0];
            2'd1:    cur_byte = head.bytes[1];
            default: cur_byte = head.bytes[2];
        endcase
    end

    // Step through the bytes of the head job
    always_comb begin
        pos_next = pos_reg;
        if (take) begin
            pos_next = run_end ? 2'd0 : pos_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            if (load) begin
                m_tvalid_reg <= !empty;
            end
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (take) begin
            m_tdata_reg <= cur_byte;
            m_tuser_reg <= run_end;
            m_tlast_reg <= run_end && head.last;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;
    assign m_tuser[0] = m_tuser_reg;

`ifndef SYNTH
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        !empty |-> (head.count != 2'd0) && (pos_reg < head.count))
        else $error("byte position beyond job");
    a_end_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser[0])
        else $error("string end not on run end");
`endif

endmodule

`default_nettype wire
